FILE: hdl/lfps_pkg.sv
// ============================================================================
// lfps_pkg
// Shared types, register map, reset values and sensor decode for the
// line-follow PID steering block.
// ============================================================================
package lfps_pkg;

  // Integral accumulator width, default for the top-level parameter
  localparam int INTEGRAL_WIDTH_DEF = 16;

  // Configuration port geometry
  localparam int ADDR_WIDTH = 5;
  localparam int DATA_WIDTH = 32;
  localparam int REG_IDX_WIDTH = 3;

  // Register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BASE_POWER     = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FEEDBACK_LIMIT = 3'd4;

  // Reset values
  localparam logic [7:0] GAIN_P_RST         = 8'd48;  // 3.0 in Q4.4
  localparam logic [7:0] GAIN_I_RST         = 8'd0;
  localparam logic [7:0] GAIN_D_RST         = 8'd0;
  localparam logic [7:0] BASE_POWER_RST     = 8'd25;
  localparam logic [7:0] FEEDBACK_LIMIT_RST = 8'd25;

  // Position error values
  localparam logic signed [3:0] ERR_P5 = 4'sd5;
  localparam logic signed [3:0] ERR_P4 = 4'sd4;
  localparam logic signed [3:0] ERR_P2 = 4'sd2;
  localparam logic signed [3:0] ERR_P1 = 4'sd1;
  localparam logic signed [3:0] ERR_Z  = 4'sd0;
  localparam logic signed [3:0] ERR_M1 = -4'sd1;
  localparam logic signed [3:0] ERR_M2 = -4'sd2;
  localparam logic signed [3:0] ERR_M4 = -4'sd4;
  localparam logic signed [3:0] ERR_M5 = -4'sd5;

  typedef struct packed {
    logic [7:0] gain_p;
    logic [7:0] gain_i;
    logic [7:0] gain_d;
    logic [7:0] base_power;
    logic [7:0] feedback_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        left_power;
    logic [7:0]        right_power;
    logic signed [3:0] position_error;
    logic signed [8:0] steer_feedback;
  } result_t;

  // Map the sensor word to a position error; keep prev on unknown patterns
  function automatic logic signed [3:0] decode_error(input logic [4:0] s,
                                                     input logic signed [3:0] prev);
    logic signed [3:0] e;
    e = prev;
    if (s[0] && !s[2] && !s[3] && !s[4]) begin
      e = s[1] ? ERR_P4 : ERR_P5;
    end else if (s[1] && !s[0] && !s[3] && !s[4]) begin
      e = s[2] ? ERR_P1 : ERR_P2;
    end else if (s[2] && !s[0] && !s[1] && !s[4]) begin
      e = s[3] ? ERR_M1 : ERR_Z;
    end else if (s[3] && !s[0] && !s[1] && !s[2]) begin
      e = s[4] ? ERR_M4 : ERR_M2;
    end else if (s[4] && !s[0] && !s[1] && !s[2] && !s[3]) begin
      e = ERR_M5;
    end
    return e;
  endfunction

endpackage

FILE: hdl/lfps_calc.sv
// ============================================================================
// lfps_calc
// One control step: decode, saturating integral, weighted PID sum,
// feedback clamp and motor power saturation.
// ============================================================================
module lfps_calc #(
  parameter int INTEGRAL_WIDTH = lfps_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic [4:0]                       sensor_bits,
  input  logic signed [3:0]                held_error,
  input  logic signed [INTEGRAL_WIDTH-1:0] error_sum,
  input  lfps_pkg::cfg_t                   cfg,
  output logic signed [INTEGRAL_WIDTH-1:0] error_sum_next,
  output lfps_pkg::result_t                result
);

  localparam int IW = INTEGRAL_WIDTH;
  localparam int WW = IW + 11;  // weighted sum width, holds all three terms

  logic signed [3:0]      err;
  logic signed [4:0]      deriv;
  logic signed [IW:0]     sum_wide;
  logic signed [12:0]     p_term;
  logic signed [IW+8:0]   i_term;
  logic signed [13:0]     d_term;
  logic signed [WW-1:0]   weighted;
  logic signed [WW-1:0]   quot;
  logic signed [WW-1:0]   lim_pos;
  logic signed [WW-1:0]   lim_neg;
  logic signed [8:0]      fb;
  logic signed [9:0]      left_wide;
  logic signed [9:0]      right_wide;

  assign err   = lfps_pkg::decode_error(sensor_bits, held_error);
  assign deriv = {err[3], err} - {held_error[3], held_error};

  // Saturate the integral at the signed bounds of its width
  assign sum_wide = {error_sum[IW-1], error_sum} + {{(IW-3){err[3]}}, err};
  always_comb begin
    if (sum_wide[IW] != sum_wide[IW-1]) begin
      error_sum_next = sum_wide[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[IW-1:0];
    end
  end

  assign p_term = $signed({1'b0, cfg.gain_p}) * err;
  assign i_term = $signed({1'b0, cfg.gain_i}) * error_sum_next;
  assign d_term = $signed({1'b0, cfg.gain_d}) * deriv;

  assign weighted = {{(WW-13){p_term[12]}}, p_term}
                  + {{(WW-IW-9){i_term[IW+8]}}, i_term}
                  + {{(WW-14){d_term[13]}}, d_term};

  // Divide by 16 toward zero: bias negatives before the shift
  assign quot = (weighted[WW-1] ? (weighted + WW'(15)) : weighted) >>> 4;

  assign lim_pos = $signed({{(WW-8){1'b0}}, cfg.feedback_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (err == lfps_pkg::ERR_Z) begin
      fb = 9'sd0;
    end else if (quot > lim_pos) begin
      fb = lim_pos[8:0];
    end else if (quot < lim_neg) begin
      fb = lim_neg[8:0];
    end else begin
      fb = quot[8:0];
    end
  end

  assign left_wide  = $signed({2'b00, cfg.base_power}) + {fb[8], fb};
  assign right_wide = $signed({2'b00, cfg.base_power}) - {fb[8], fb};

  always_comb begin
    result.position_error = err;
    result.steer_feedback = fb;
    if (left_wide[9]) begin
      result.left_power = 8'd0;
    end else if (left_wide[8]) begin
      result.left_power = 8'd255;
    end else begin
      result.left_power = left_wide[7:0];
    end
    if (right_wide[9]) begin
      result.right_power = 8'd0;
    end else if (right_wide[8]) begin
      result.right_power = 8'd255;
    end else begin
      result.right_power = right_wide[7:0];
    end
  end

endmodule

FILE: hdl/line_follow_pid_steering.sv
// ============================================================================
// line_follow_pid_steering
// PID steering for a five-sensor line follower: sensor word in, motor powers
// and the error and feedback used out.
// ============================================================================
// Usage:
//   Input channel: sensor_bits with in_valid / in_stall. A word is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel: left_power, right_power, position_error, steer_feedback
//   with out_valid / out_stall; one result word per input word, in order.
//   Path: an accepted word lands in the input register at its edge and its
//   result is loaded into the output register once that register is free,
//   so a stall on the output can hold it in the input register.
//   Throughput: one word per cycle while the output register is free. The
//   held error and the integral update in the same cycle that a word moves
//   into the output register, so each word sees the state its predecessor left.
//   Stall: while out_stall holds a result, the input register keeps its word
//   and in_stall rises only once both registers are full.
//   Reset (rst, synchronous): drop both valid flags, clear the held error and
//   the integral, load the gain, base power and limit reset values.
//   Configuration: APB port, registers at byte address 4*index; write only
//   while no word is in flight. Reads return the register value.
// ============================================================================
module line_follow_pid_steering #(
  parameter int INTEGRAL_WIDTH = lfps_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input word
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [4:0]                      sensor_bits,
  // result word
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      left_power,
  output logic [7:0]                      right_power,
  output logic signed [3:0]               position_error,
  output logic signed [8:0]               steer_feedback,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lfps_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [lfps_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [lfps_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready
);

  lfps_pkg::cfg_t                      cfg;
  logic [lfps_pkg::REG_IDX_WIDTH-1:0]  reg_idx;
  logic                                cfg_wr;

  logic                                s1_valid;
  logic [4:0]                          s1_sensor;
  logic                                out_free;
  logic                                advance;

  logic signed [3:0]                   held_error;
  logic signed [INTEGRAL_WIDTH-1:0]    error_sum;
  logic signed [INTEGRAL_WIDTH-1:0]    error_sum_next;
  lfps_pkg::result_t                   result;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[lfps_pkg::ADDR_WIDTH-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= lfps_pkg::GAIN_P_RST;
      cfg.gain_i         <= lfps_pkg::GAIN_I_RST;
      cfg.gain_d         <= lfps_pkg::GAIN_D_RST;
      cfg.base_power     <= lfps_pkg::BASE_POWER_RST;
      cfg.feedback_limit <= lfps_pkg::FEEDBACK_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        lfps_pkg::REG_GAIN_P:         cfg.gain_p         <= pwdata[7:0];
        lfps_pkg::REG_GAIN_I:         cfg.gain_i         <= pwdata[7:0];
        lfps_pkg::REG_GAIN_D:         cfg.gain_d         <= pwdata[7:0];
        lfps_pkg::REG_BASE_POWER:     cfg.base_power     <= pwdata[7:0];
        lfps_pkg::REG_FEEDBACK_LIMIT: cfg.feedback_limit <= pwdata[7:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfps_pkg::REG_GAIN_P:         prdata = {24'd0, cfg.gain_p};
      lfps_pkg::REG_GAIN_I:         prdata = {24'd0, cfg.gain_i};
      lfps_pkg::REG_GAIN_D:         prdata = {24'd0, cfg.gain_d};
      lfps_pkg::REG_BASE_POWER:     prdata = {24'd0, cfg.base_power};
      lfps_pkg::REG_FEEDBACK_LIMIT: prdata = {24'd0, cfg.feedback_limit};
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the output register frees when empty or being taken; the input
  // register moves forward whenever the output register can accept it.
  // --------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign advance  = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_sensor <= sensor_bits;
    end
  end

  // --------------------------------------------------------------------------
  // Control step
  // --------------------------------------------------------------------------
  lfps_calc #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_calc (
    .sensor_bits    (s1_sensor),
    .held_error     (held_error),
    .error_sum      (error_sum),
    .cfg            (cfg),
    .error_sum_next (error_sum_next),
    .result         (result)
  );

  // Loop state advances with the word it belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      held_error <= '0;
      error_sum  <= '0;
    end else if (advance) begin
      held_error <= result.position_error;
      error_sum  <= error_sum_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_power     <= result.left_power;
      right_power    <= result.right_power;
      position_error <= result.position_error;
      steer_feedback <= result.steer_feedback;
    end
  end

endmodule
